[src/lart_pkg.sv]
// Shared types and constants for the range-assign / range-max tree unit.
package lart_pkg;

    localparam int DW = 32;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        C_NONE,
        C_CLEAR,
        C_LOAD,
        C_PUSH_RD,
        C_PUSH_W1,
        C_PUSH_W2,
        C_PUSH_W3,
        C_WALK_INIT,
        C_ASG_LO,
        C_ASG_HI,
        C_RD_LO,
        C_RD_HI,
        C_QCMP,
        C_SHIFT,
        C_REF_INIT,
        C_REF_RD0,
        C_REF_RD1,
        C_REF_WR,
        C_EMIT
    } t_cmd;

    // Datapath status seen by the controller
    typedef struct packed {
        logic clr_last;
        logic err;
        logic act;
        logic tag_valid;
        logic lo_ge_hi;
        logic lo_odd;
        logic hi_odd;
        logic push_last;
        logic ref_last;
        logic out_busy;
    } t_status;

endpackage

[src/lart_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module lart_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/lart_ctrl.sv]
// Controller state machine sequencing clear, push, walk and refresh phases.
module lart_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lart_pkg::t_status i_status,
    output lart_pkg::t_cmd   o_cmd,
    output logic             o_stall
);

    typedef enum logic [17:0] {
        S_CLEAR  = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_CHECK  = 18'b000000000000000100,
        S_P_RD   = 18'b000000000000001000,
        S_P_CHK  = 18'b000000000000010000,
        S_P_W1   = 18'b000000000000100000,
        S_P_W2   = 18'b000000000001000000,
        S_P_W3   = 18'b000000000010000000,
        S_W_INIT = 18'b000000000100000000,
        S_W_LO   = 18'b000000001000000000,
        S_W_LOQ  = 18'b000000010000000000,
        S_W_HI   = 18'b000000100000000000,
        S_W_HIQ  = 18'b000001000000000000,
        S_W_SHFT = 18'b000010000000000000,
        S_R_RD0  = 18'b000100000000000000,
        S_R_RD1  = 18'b001000000000000000,
        S_R_WR   = 18'b010000000000000000,
        S_DONE   = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_cmd   = lart_pkg::C_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = lart_pkg::C_CLEAR;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = lart_pkg::C_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.err ? S_DONE : S_P_RD;
            end
            S_P_RD: begin
                o_cmd   = lart_pkg::C_PUSH_RD;
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                if (i_status.tag_valid) begin
                    n_state = S_P_W1;
                end else begin
                    // nothing pending here: advance directly (W3 advances too)
                    o_cmd   = lart_pkg::C_PUSH_W3;
                    n_state = i_status.push_last ? S_W_INIT : S_P_RD;
                end
            end
            S_P_W1: begin
                o_cmd   = lart_pkg::C_PUSH_W1;
                n_state = S_P_W2;
            end
            S_P_W2: begin
                o_cmd   = lart_pkg::C_PUSH_W2;
                n_state = S_P_W3;
            end
            S_P_W3: begin
                o_cmd   = lart_pkg::C_PUSH_W3;
                n_state = i_status.push_last ? S_W_INIT : S_P_RD;
            end
            S_W_INIT: begin
                o_cmd   = lart_pkg::C_WALK_INIT;
                n_state = S_W_LO;
            end
            S_W_LO: begin
                if (i_status.lo_ge_hi) begin
                    if (!i_status.act) begin
                        o_cmd   = lart_pkg::C_REF_INIT;
                        n_state = S_R_RD0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_status.lo_odd) begin
                    o_cmd   = i_status.act ? lart_pkg::C_RD_LO : lart_pkg::C_ASG_LO;
                    n_state = i_status.act ? S_W_LOQ : S_W_HI;
                end else begin
                    n_state = S_W_HI;
                end
            end
            S_W_LOQ: begin
                o_cmd   = lart_pkg::C_QCMP;
                n_state = S_W_HI;
            end
            S_W_HI: begin
                if (i_status.hi_odd) begin
                    o_cmd   = i_status.act ? lart_pkg::C_RD_HI : lart_pkg::C_ASG_HI;
                    n_state = i_status.act ? S_W_HIQ : S_W_SHFT;
                end else begin
                    n_state = S_W_SHFT;
                end
            end
            S_W_HIQ: begin
                o_cmd   = lart_pkg::C_QCMP;
                n_state = S_W_SHFT;
            end
            S_W_SHFT: begin
                o_cmd   = lart_pkg::C_SHIFT;
                n_state = S_W_LO;
            end
            S_R_RD0: begin
                o_cmd   = lart_pkg::C_REF_RD0;
                n_state = S_R_RD1;
            end
            S_R_RD1: begin
                o_cmd   = lart_pkg::C_REF_RD1;
                n_state = S_R_WR;
            end
            S_R_WR: begin
                o_cmd   = lart_pkg::C_REF_WR;
                n_state = i_status.ref_last ? S_DONE : S_R_RD0;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd   = lart_pkg::C_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[src/lart_dpath.sv]
// Datapath: tree memories, path/walk registers, max compare and output register.
module lart_dpath #(
    parameter int LEAVES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lart_pkg::t_cmd    i_cmd,
    output lart_pkg::t_status o_status,
    input  logic              i_action,
    input  logic [9:0]        i_left_index,
    input  logic [9:0]        i_right_index,
    input  logic [31:0]       i_new_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_max_value,
    output logic              o_range_error
);

    localparam int L    = $clog2(LEAVES);
    localparam int NW   = L + 1;
    localparam int HW   = L + 2;
    localparam int KW   = $clog2(L + 1);
    localparam int BASE = 1 << L;
    localparam int DW   = lart_pkg::DW;

    logic [NW-1:0] r_lo_leaf, r_hi_leaf, r_x, n_x, r_p, r_clr;
    logic [HW-1:0] r_lo, r_hi;
    logic [KW-1:0] r_k;
    logic          r_side, r_act, r_err;
    logic [DW-1:0] r_val, r_best, r_a;

    logic          node_we, tag_we;
    logic [NW-1:0] node_waddr;
    logic [L-1:0]  tag_waddr;
    logic [DW-1:0] node_wdata, node_rdata;
    logic [DW:0]   tag_wdata, tag_rdata;

    logic [NW-1:0] path, c0, c1, hi_m1;
    logic [DW-1:0] sub, tval;
    logic [31:0]   lo_leaf_w, hi_leaf_w;
    logic          x_internal;

    lart_ram #(.WIDTH(DW), .DEPTH(2 * BASE)) u_node (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(n_x),
        .o_rdata(node_rdata)
    );

    lart_ram #(.WIDTH(DW + 1), .DEPTH(BASE)) u_tag (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr(tag_waddr),
        .i_wdata(tag_wdata),
        .i_raddr(n_x[L-1:0]),
        .o_rdata(tag_rdata)
    );

    // Path node at the current level and side, and helpers
    assign path       = NW'((r_side ? r_hi_leaf : r_lo_leaf) >> r_k);
    assign c0         = {r_x[NW-2:0], 1'b0};
    assign c1         = {r_x[NW-2:0], 1'b1};
    assign hi_m1      = NW'(r_hi - HW'(1));
    assign tval       = tag_rdata[DW-1:0];
    assign x_internal = (r_x < NW'(BASE));
    assign sub        = (x_internal && tag_rdata[DW]) ? tval : node_rdata;
    assign lo_leaf_w  = 32'(BASE) + {22'd0, i_left_index};
    assign hi_leaf_w  = 32'(BASE) + {22'd0, i_right_index};

    // Status
    always_comb begin
        o_status.clr_last  = (r_clr == {NW{1'b1}});
        o_status.err       = r_err;
        o_status.act       = r_act;
        o_status.tag_valid = tag_rdata[DW];
        o_status.lo_ge_hi  = (r_lo >= r_hi);
        o_status.lo_odd    = r_lo[0];
        o_status.hi_odd    = r_hi[0];
        o_status.push_last = r_side && (r_k == KW'(1));
        o_status.ref_last  = r_side && (r_k == KW'(L));
        o_status.out_busy  = o_valid && i_stall;
    end

    // Memory write port and read address
    always_comb begin
        n_x        = r_x;
        node_we    = 1'b0;
        node_waddr = r_x;
        node_wdata = r_val;
        tag_we     = 1'b0;
        tag_waddr  = r_x[L-1:0];
        tag_wdata  = {1'b1, r_val};
        case (i_cmd)
            lart_pkg::C_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = r_clr;
                node_wdata = '0;
                tag_we     = 1'b1;
                tag_waddr  = r_clr[L-1:0];
                tag_wdata  = '0;
            end
            lart_pkg::C_PUSH_RD: begin
                n_x = path;
            end
            lart_pkg::C_PUSH_W1: begin
                node_we    = 1'b1;
                node_waddr = c0;
                node_wdata = tval;
                tag_we     = (c0 < NW'(BASE));
                tag_waddr  = c0[L-1:0];
                tag_wdata  = {1'b1, tval};
            end
            lart_pkg::C_PUSH_W2: begin
                node_we    = 1'b1;
                node_waddr = c1;
                node_wdata = tval;
                tag_we     = (c1 < NW'(BASE));
                tag_waddr  = c1[L-1:0];
                tag_wdata  = {1'b1, tval};
            end
            lart_pkg::C_PUSH_W3: begin
                // only acts when a tag was pending at this node
                node_we    = tag_rdata[DW];
                node_wdata = tval;
                tag_we     = tag_rdata[DW];
                tag_wdata  = {1'b0, tval};
            end
            lart_pkg::C_ASG_LO: begin
                node_we    = 1'b1;
                node_waddr = r_lo[NW-1:0];
                tag_we     = (r_lo < HW'(BASE));
                tag_waddr  = r_lo[L-1:0];
            end
            lart_pkg::C_ASG_HI: begin
                node_we    = 1'b1;
                node_waddr = hi_m1;
                tag_we     = (hi_m1 < NW'(BASE));
                tag_waddr  = hi_m1[L-1:0];
            end
            lart_pkg::C_RD_LO: begin
                n_x = r_lo[NW-1:0];
            end
            lart_pkg::C_RD_HI: begin
                n_x = hi_m1;
            end
            lart_pkg::C_REF_RD0: begin
                n_x = {path[NW-2:0], 1'b0};
            end
            lart_pkg::C_REF_RD1: begin
                n_x = {r_p[NW-2:0], 1'b1};
            end
            lart_pkg::C_REF_WR: begin
                node_we    = 1'b1;
                node_waddr = r_p;
                node_wdata = (r_a > sub) ? r_a : sub;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd == lart_pkg::C_CLEAR) r_clr <= r_clr + NW'(1);
            if (i_cmd == lart_pkg::C_EMIT) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        case (i_cmd)
            lart_pkg::C_LOAD: begin
                r_act     <= i_action;
                r_val     <= i_new_value;
                r_err     <= (i_left_index > i_right_index)
                             || ({22'd0, i_right_index} >= 32'(LEAVES));
                r_lo_leaf <= NW'(lo_leaf_w);
                r_hi_leaf <= NW'(hi_leaf_w);
                r_k       <= KW'(L);
                r_side    <= 1'b0;
                r_best    <= '0;
            end
            lart_pkg::C_PUSH_W3: begin
                r_side <= ~r_side;
                if (r_side) r_k <= r_k - KW'(1);
            end
            lart_pkg::C_WALK_INIT: begin
                r_lo <= HW'(r_lo_leaf);
                r_hi <= HW'(r_hi_leaf) + HW'(1);
            end
            lart_pkg::C_ASG_LO, lart_pkg::C_RD_LO: begin
                r_lo <= r_lo + HW'(1);
            end
            lart_pkg::C_ASG_HI, lart_pkg::C_RD_HI: begin
                r_hi <= r_hi - HW'(1);
            end
            lart_pkg::C_QCMP: begin
                if (sub > r_best) r_best <= sub;
            end
            lart_pkg::C_SHIFT: begin
                r_lo <= r_lo >> 1;
                r_hi <= r_hi >> 1;
            end
            lart_pkg::C_REF_INIT: begin
                r_k    <= KW'(1);
                r_side <= 1'b0;
            end
            lart_pkg::C_REF_RD0: begin
                r_p <= path;
            end
            lart_pkg::C_REF_RD1: begin
                r_a <= sub;
            end
            lart_pkg::C_REF_WR: begin
                r_side <= ~r_side;
                if (r_side) r_k <= r_k + KW'(1);
            end
            lart_pkg::C_EMIT: begin
                o_max_value   <= r_best;
                o_range_error <= r_err;
            end
            default: begin
            end
        endcase
    end

endmodule

[src/lazy_assign_range_max_tree_unit.sv]
// Top level of the range-assign / range-maximum segment tree unit.
// Usage:
//  - Input channel (i_valid / o_stall) carries one item: i_action (0 assign,
//    1 query), i_left_index, i_right_index, i_new_value. A transfer happens
//    at a clock edge with i_valid high and o_stall low.
//  - Output channel (o_valid / i_stall) returns one result per item:
//    o_max_value (range max for a query, zero for an assign) and
//    o_range_error (reversed bounds or right index at or past LEAVES; state kept).
//  - One item is processed at a time. With L = clog2(LEAVES) levels, an item
//    runs a tag push along both boundary paths (a read per level, plus three
//    writes where a tag is pending), then the walk, level by level, and for
//    an assign a bottom-up refresh along both boundary paths.
//  - A bad range skips the push, walk and refresh and goes to the result.
//  - After reset the node and tag memories are cleared, one entry a cycle,
//    over every node address; o_stall stays high meanwhile.
//  - The finished result sits in an output register; the block takes the
//    next item while it waits. If the receiver still stalls when the next
//    result is ready, the unit holds that result and keeps o_stall high.
module lazy_assign_range_max_tree_unit #(
    parameter int LEAVES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [9:0]  i_left_index,
    input  logic [9:0]  i_right_index,
    input  logic [31:0] i_new_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_max_value,
    output logic        o_range_error
);

    lart_pkg::t_cmd    cmd;
    lart_pkg::t_status status;

    lart_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_status(status),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    lart_dpath #(.LEAVES(LEAVES)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_action     (i_action),
        .i_left_index (i_left_index),
        .i_right_index(i_right_index),
        .i_new_value  (i_new_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_max_value  (o_max_value),
        .o_range_error(o_range_error)
    );

endmodule

[tb/sv/tb_lazy_assign_range_max_tree_unit.sv]
// Testbench for the range-assign / range-max tree unit: random and directed traffic, scoreboard.
`timescale 1ns / 100ps

module tb_lazy_assign_range_max_tree_unit;

    localparam int NLEAF = 1024;
    localparam int WDOG_LIMIT = 200000;

    typedef struct packed {
        logic        action;
        logic [9:0]  left_index;
        logic [9:0]  right_index;
        logic [31:0] new_value;
    } t_item;

    typedef struct packed {
        logic [31:0] max_value;
        logic        range_error;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [9:0]  i_left_index;
    logic [9:0]  i_right_index;
    logic [31:0] i_new_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_max_value;
    logic        o_range_error;

    lazy_assign_range_max_tree_unit #(.LEAVES(NLEAF)) dut (.*);

    // Clock, 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor state: plain slot array is enough to model range assign / max
    logic [31:0] slot_mem [NLEAF];
    t_item       pending_items [$];
    t_result     expected_results [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_recv;
    int          mismatch_cnt;
    int          result_cnt;
    int          error_cnt;
    int          wdog_cnt;
    bit          in_reset;
    bit          in_xfer;

    function automatic t_result predict_tree(t_item it);
        t_result r;
        r.max_value = '0;
        r.range_error = 1'b0;
        if (it.left_index > it.right_index || int'(it.right_index) >= NLEAF) begin
            r.range_error = 1'b1;
        end else begin
            for (int s = it.left_index; s <= it.right_index; s++) begin
                if (it.action == 1'b0) slot_mem[s] = it.new_value;
                else if (slot_mem[s] > r.max_value) r.max_value = slot_mem[s];
            end
        end
        return r;
    endfunction

    function automatic void queue_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    // Driver: presents queued items at the falling edge
    always @(negedge i_clk) begin
        if (in_reset) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_xfer) begin
            // hold stalled payload
        end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            t_item it;
            it = pending_items.pop_front();
            i_valid <= 1'b1;
            i_action <= it.action;
            i_left_index <= it.left_index;
            i_right_index <= it.right_index;
            i_new_value <= it.new_value;
        end else begin
            i_valid <= 1'b0;
        end
        if (in_reset) i_stall <= 1'b0;
        else if (hold_recv > 0) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Long receiver hold-off, counted in its own process
    always @(posedge i_clk) begin
        if (hold_recv > 0) hold_recv <= hold_recv - 1;
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        in_xfer <= i_valid && !o_stall;
        if (!in_reset) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog_cnt <= 0;
            else wdog_cnt <= wdog_cnt + 1;
            if (i_valid && !o_stall) begin
                t_item it;
                it = {i_action, i_left_index, i_right_index, i_new_value};
                expected_results = {expected_results, predict_tree(it)};
            end
            if (o_valid && !i_stall) begin
                result_cnt <= result_cnt + 1;
                if (expected_results.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) $display("ERROR: result with nothing expected");
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (e.range_error) error_cnt <= error_cnt + 1;
                    if (e.max_value !== o_max_value || e.range_error !== o_range_error) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("ERROR: max exp %h got %h, err exp %b got %b",
                                     e.max_value, o_max_value, e.range_error, o_range_error);
                    end
                end
            end
            if (wdog_cnt > WDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", WDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic t_item make_item(logic act, int lo, int hi, logic [31:0] v);
        t_item it;
        it.action = act;
        it.left_index = lo[9:0];
        it.right_index = hi[9:0];
        it.new_value = v;
        return it;
    endfunction

    // Random item: mostly valid ranges, mostly short, some full-width and bad ones
    function automatic t_item random_item();
        int lo, hi, len, kind;
        logic [31:0] v;
        kind = $urandom_range(99);
        v = $urandom();
        if ($urandom_range(3) == 0) v = v >> $urandom_range(31);
        lo = $urandom_range(NLEAF - 1);
        if (kind < 8) begin
            hi = $urandom_range(NLEAF - 1);
            if (hi >= lo && lo != hi) begin
                len = lo; lo = hi; hi = len;
            end
        end else if (kind < 15) begin
            lo = $urandom_range(40);
            hi = NLEAF - 1 - $urandom_range(40);
        end else begin
            len = (kind < 60) ? $urandom_range(8) : $urandom_range(200);
            hi = lo + len;
            if (hi > NLEAF - 1) hi = NLEAF - 1;
        end
        return make_item($urandom_range(1), lo, hi, v);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) queue_item(random_item());
        wait_drained();
    endtask

    initial begin
        in_reset = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = 1'b0;
        i_left_index = '0;
        i_right_index = '0;
        i_new_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 0;
        mismatch_cnt = 0;
        result_cnt = 0;
        error_cnt = 0;
        wdog_cnt = 0;
        for (int s = 0; s < NLEAF; s++) slot_mem[s] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        in_reset = 1'b0;

        // Directed: empty tree, extremes, bad ranges, overlapping assigns
        queue_item(make_item(1'b1, 0, NLEAF - 1, '0));
        queue_item(make_item(1'b0, 0, 0, 32'hFFFF_FFFF));
        queue_item(make_item(1'b0, NLEAF - 1, NLEAF - 1, 32'h0000_0001));
        queue_item(make_item(1'b1, 0, NLEAF - 1, '0));
        queue_item(make_item(1'b1, 1, NLEAF - 1, '0));
        queue_item(make_item(1'b0, 0, NLEAF - 1, 32'h5555_AAAA));
        queue_item(make_item(1'b1, 3, 700, 32'hFFFF_FFFF));
        queue_item(make_item(1'b0, 100, 200, 32'hAAAA_5555));
        queue_item(make_item(1'b0, 150, 150, 32'h0000_0000));
        queue_item(make_item(1'b1, 150, 150, '0));
        queue_item(make_item(1'b1, 99, 151, '0));
        queue_item(make_item(1'b0, 120, 180, 32'h0000_0002));
        queue_item(make_item(1'b1, 0, NLEAF - 1, '0));
        queue_item(make_item(1'b1, 5, 4, '0));
        queue_item(make_item(1'b0, NLEAF - 1, 0, 32'hFFFF_FFFF));
        queue_item(make_item(1'b1, 0, NLEAF - 1, '0));
        queue_item(make_item(1'b0, 511, 512, 32'h8000_0000));
        queue_item(make_item(1'b1, 512, 1023, '0));
        queue_item(make_item(1'b1, 0, 511, '0));
        wait_drained();

        run_phase(350, 0, 0);
        run_phase(200, 86, 0);
        run_phase(200, 0, 86);
        run_phase(250, 26, 26);

        // Long receiver hold-off while the sender keeps offering items
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 3000;
        for (int k = 0; k < 20; k++) queue_item(random_item());
        wait_drained();

        run_phase(300, 0, 0);

        $display("Ran %0d results, %0d bad-range items, over assign/query traffic",
                 result_cnt, error_cnt);
        $display("Phases: back-to-back, sender idle, receiver stall, mixed, long hold-off");
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d", mismatch_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
